@@ rtl/openpgp_packet_framer_assert.svh @@
// assertion macros for the packet framer checker
`ifndef OPENPGP_PACKET_FRAMER_ASSERT_SVH
`define OPENPGP_PACKET_FRAMER_ASSERT_SVH

// clocked assertion, off while reset is high
`define OPF_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds through reset
`define OPF_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/opf_pkg.sv @@
// types and constants shared by the packet framer modules
package opf_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NEWLEN,
    PH_TWO,
    PH_MULTI,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOTAG = 2'd1,
    ST_INDET = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  localparam logic       KIND_BYTE    = 1'b0;
  localparam logic [7:0] LEN_TWO_MIN  = 8'd192;
  localparam logic [7:0] LEN_TWO_MAX  = 8'd223;
  localparam logic [7:0] LEN_FIVE     = 8'd255;
  localparam logic [1:0] OLD_LEN_ONE  = 2'd0;
  localparam logic [1:0] OLD_LEN_TWO  = 2'd1;
  localparam logic [1:0] OLD_LEN_INDET = 2'd3;
  localparam logic [3:0] OLD_TAG_HIGH = 4'h8;

  typedef struct packed {
    logic          byte_valid;
    logic [7:0]    out_byte;
    logic          packet_done;
    status_t       status;
    logic [31:0]   packet_bytes;
  } result_t;

endpackage

@@ rtl/opf_parser.sv @@
// header parser: state registers and the next-state and result logic
module opf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              kind,
  input  logic [7:0]        data_byte,
  output opf_pkg::result_t  result
);

  opf_pkg::phase_t phase, phase_next;
  logic [31:0] length_accum, length_accum_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] body_left, body_left_next;
  logic        partial_chunk, partial_chunk_next;
  logic [31:0] bytes_buffered, bytes_buffered_next;

  logic        have_len;
  logic [31:0] len;
  logic        len_partial;
  logic        done;
  logic [2:0]  left_dec;
  logic [31:0] body_dec;
  logic [31:0] acc_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= opf_pkg::PH_IDLE;
      length_accum      <= '0;
      length_bytes_left <= '0;
      body_left         <= '0;
      partial_chunk     <= 1'b0;
      bytes_buffered    <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      length_accum      <= length_accum_next;
      length_bytes_left <= length_bytes_left_next;
      body_left         <= body_left_next;
      partial_chunk     <= partial_chunk_next;
      bytes_buffered    <= bytes_buffered_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    length_accum_next      = length_accum;
    length_bytes_left_next = length_bytes_left;
    body_left_next         = body_left;
    partial_chunk_next     = partial_chunk;
    bytes_buffered_next    = bytes_buffered;
    result                 = '0;
    result.status          = opf_pkg::ST_OK;
    have_len               = 1'b0;
    len                    = '0;
    len_partial            = 1'b0;
    done                   = 1'b0;
    left_dec  = (length_bytes_left == 3'd0) ? 3'd0 : length_bytes_left - 3'd1;
    body_dec  = (body_left == 32'd0) ? 32'd0 : body_left - 32'd1;
    acc_shift = {length_accum[23:0], data_byte};

    if (kind != opf_pkg::KIND_BYTE) begin
      if (phase != opf_pkg::PH_IDLE) begin
        result.status = opf_pkg::ST_TRUNC;
      end
      phase_next             = opf_pkg::PH_IDLE;
      length_accum_next      = '0;
      length_bytes_left_next = '0;
      body_left_next         = '0;
      partial_chunk_next     = 1'b0;
      bytes_buffered_next    = '0;
    end else begin
      unique case (phase)
        opf_pkg::PH_IDLE: begin
          if (!data_byte[7]) begin
            result.status = opf_pkg::ST_NOTAG;
          end else if (data_byte[6]) begin
            result.byte_valid   = 1'b1;
            result.out_byte     = data_byte;
            bytes_buffered_next = 32'd1;
            phase_next          = opf_pkg::PH_NEWLEN;
          end else if (data_byte[1:0] == opf_pkg::OLD_LEN_INDET) begin
            result.status = opf_pkg::ST_INDET;
          end else begin
            result.byte_valid   = 1'b1;
            result.out_byte     = {opf_pkg::OLD_TAG_HIGH, data_byte[5:2]};
            bytes_buffered_next = 32'd1;
            length_accum_next   = '0;
            unique case (data_byte[1:0])
              opf_pkg::OLD_LEN_ONE: length_bytes_left_next = 3'd1;
              opf_pkg::OLD_LEN_TWO: length_bytes_left_next = 3'd2;
              default:              length_bytes_left_next = 3'd4;
            endcase
            phase_next = opf_pkg::PH_MULTI;
          end
        end
        opf_pkg::PH_NEWLEN: begin
          if (data_byte < opf_pkg::LEN_TWO_MIN) begin
            have_len = 1'b1;
            len      = {24'd0, data_byte};
          end else if (data_byte <= opf_pkg::LEN_TWO_MAX) begin
            length_accum_next = {19'd0, data_byte[4:0], 8'd0};
            phase_next        = opf_pkg::PH_TWO;
          end else if (data_byte != opf_pkg::LEN_FIVE) begin
            have_len    = 1'b1;
            len_partial = 1'b1;
            len         = 32'd1 << data_byte[4:0];
          end else begin
            length_accum_next      = '0;
            length_bytes_left_next = 3'd4;
            phase_next             = opf_pkg::PH_MULTI;
          end
        end
        opf_pkg::PH_TWO: begin
          have_len = 1'b1;
          len      = length_accum + {24'd0, data_byte} + {24'd0, opf_pkg::LEN_TWO_MIN};
        end
        opf_pkg::PH_MULTI: begin
          length_accum_next      = acc_shift;
          length_bytes_left_next = left_dec;
          if (left_dec == 3'd0) begin
            have_len = 1'b1;
            len      = acc_shift;
          end
        end
        opf_pkg::PH_BODY: begin
          result.byte_valid = 1'b1;
          result.out_byte   = data_byte;
          if (bytes_buffered != 32'hFFFF_FFFF) begin
            bytes_buffered_next = bytes_buffered + 32'd1;
          end
          body_left_next = body_dec;
          if (body_dec == 32'd0) begin
            if (partial_chunk) begin
              partial_chunk_next = 1'b0;
              phase_next         = opf_pkg::PH_NEWLEN;
            end else begin
              done = 1'b1;
            end
          end
        end
        default: begin
          phase_next = opf_pkg::PH_IDLE;
        end
      endcase

      if (have_len) begin
        partial_chunk_next     = len_partial;
        body_left_next         = len;
        length_accum_next      = '0;
        length_bytes_left_next = '0;
        if (len == 32'd0) begin
          if (len_partial) begin
            phase_next = opf_pkg::PH_NEWLEN;
          end else begin
            done = 1'b1;
          end
        end else begin
          phase_next = opf_pkg::PH_BODY;
        end
      end

      if (done) begin
        result.packet_done  = 1'b1;
        result.packet_bytes = bytes_buffered_next;
      end

      // errors and finished packets leave the parser idle and clean
      if (done || result.status != opf_pkg::ST_OK) begin
        phase_next             = opf_pkg::PH_IDLE;
        length_accum_next      = '0;
        length_bytes_left_next = '0;
        body_left_next         = '0;
        partial_chunk_next     = 1'b0;
        bytes_buffered_next    = '0;
      end
    end
  end

endmodule

@@ rtl/opf_out_reg.sv @@
// result register with valid and stall towards the consumer
module opf_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  opf_pkg::result_t  result_next,
  output logic              full_stall,
  output logic              result_valid,
  input  logic              result_stall,
  output opf_pkg::result_t  result
);

  logic result_valid_next;

  assign full_stall = result_valid && result_stall;

  always_comb begin
    if (load) begin
      result_valid_next = 1'b1;
    end else if (result_stall) begin
      result_valid_next = result_valid;
    end else begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/openpgp_packet_framer.sv @@
// packet framer top level: parser and result register
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   item     | item_valid / item_stall     | kind, data_byte
//   result   | result_valid / result_stall | byte_valid, out_byte, packet_done,
//            |                             | status, packet_bytes
//
// one item per clock while item_stall is low; its result appears in the cycle after acceptance
// the parser state and its 32-bit adds and compares set the path to the result register
// rst clears the parser to idle and empties the result register
// a stalled result holds; item_stall is high only while a result waits and is stalled
module openpgp_packet_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        byte_valid,
  output logic [7:0]  out_byte,
  output logic        packet_done,
  output logic [1:0]  status,
  output logic [31:0] packet_bytes
);

  logic             accept;
  opf_pkg::result_t parsed;
  opf_pkg::result_t held;

  assign accept = item_valid && !item_stall;

  opf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .data_byte (data_byte),
    .result    (parsed)
  );

  opf_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .result_next  (parsed),
    .full_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (held)
  );

  assign byte_valid   = held.byte_valid;
  assign out_byte     = held.out_byte;
  assign packet_done  = held.packet_done;
  assign status       = held.status;
  assign packet_bytes = held.packet_bytes;

endmodule

@@ rtl/opf_checker.sv @@
// port checker for the packet framer and its bind
`include "openpgp_packet_framer_assert.svh"

module opf_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        byte_valid,
  input logic [7:0]  out_byte,
  input logic        packet_done,
  input logic [1:0]  status
);

  logic waiting;
  logic no_byte;
  logic is_err;
  logic quiet;

  assign waiting = result_valid && result_stall;
  assign no_byte = result_valid && !byte_valid;
  assign is_err  = result_valid && (status != opf_pkg::ST_OK);
  assign quiet   = !byte_valid && !packet_done;

  `OPF_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !result_valid, "result after reset")
  `OPF_ASSERT(a_valid_holds, clk, rst, waiting |=> result_valid, "result dropped")
  `OPF_ASSERT(a_idle_byte_zero, clk, rst, no_byte |-> out_byte == 8'd0, "stray byte")
  `OPF_ASSERT(a_error_quiet, clk, rst, is_err |-> quiet, "error with output")

endmodule

bind openpgp_packet_framer opf_checker u_opf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .byte_valid   (byte_valid),
  .out_byte     (out_byte),
  .packet_done  (packet_done),
  .status       (status)
);

@@ dv/openpgp_packet_framer_tb.sv @@
// self-checking testbench for the packet framer: directed table, then random packet streams
`timescale 1ns / 100ps

module openpgp_packet_framer_tb;

  localparam logic KIND_END     = 1'b1;
  localparam int   LIMIT_CYCLES = 400000;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   RANDOM_ITEMS = 800;

  localparam opf_pkg::result_t R_CLEAN = '{1'b0, 8'h00, 1'b0, opf_pkg::ST_OK, 32'd0};
  localparam opf_pkg::result_t R_NOTAG = '{1'b0, 8'h00, 1'b0, opf_pkg::ST_NOTAG, 32'd0};
  localparam opf_pkg::result_t R_INDET = '{1'b0, 8'h00, 1'b0, opf_pkg::ST_INDET, 32'd0};
  localparam opf_pkg::result_t R_TRUNC = '{1'b0, 8'h00, 1'b0, opf_pkg::ST_TRUNC, 32'd0};
  localparam opf_pkg::result_t R_EMPTY = '{1'b0, 8'h00, 1'b1, opf_pkg::ST_OK, 32'd1};

  typedef struct packed {
    logic             k;
    logic [7:0]       b;
    logic             typed;
    opf_pkg::result_t want;
  } step_row_t;

  localparam step_row_t DIR_ROWS [23] = '{
    '{KIND_END,           8'h00, 1'b1, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h7F, 1'b1, R_NOTAG},
    '{opf_pkg::KIND_BYTE, 8'h8B, 1'b1, R_INDET},
    '{opf_pkg::KIND_BYTE, 8'hFF, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h00, 1'b1, R_EMPTY},
    '{opf_pkg::KIND_BYTE, 8'hBD, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h00, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h01, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'hFF, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h86, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h00, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h00, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h00, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'h00, 1'b1, R_EMPTY},
    '{opf_pkg::KIND_BYTE, 8'hC1, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'hE0, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'hAA, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'hDF, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'hFF, 1'b0, R_CLEAN},
    '{KIND_END,           8'h5A, 1'b1, R_TRUNC},
    '{opf_pkg::KIND_BYTE, 8'hC3, 1'b0, R_CLEAN},
    '{opf_pkg::KIND_BYTE, 8'hFE, 1'b0, R_CLEAN},
    '{KIND_END,           8'hA5, 1'b1, R_TRUNC}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        kind = opf_pkg::KIND_BYTE;
  logic [7:0]  data_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        packet_done;
  logic [1:0]  status;
  logic [31:0] packet_bytes;

  // framer state as predicted
  opf_pkg::phase_t fr_phase = opf_pkg::PH_IDLE;
  logic [31:0]     fr_accum = '0;
  logic [2:0]      fr_len_left = '0;
  logic [31:0]     fr_body_left = '0;
  logic            fr_partial = 1'b0;
  logic [31:0]     fr_count = '0;

  opf_pkg::result_t frame_q [$];
  int      bad_count = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  int      send_gap_pct = 17;
  int      recv_stall_pct = 85;

  openpgp_packet_framer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .byte_valid   (byte_valid),
    .out_byte     (out_byte),
    .packet_done  (packet_done),
    .status       (status),
    .packet_bytes (packet_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic frame_clear();
    fr_phase     = opf_pkg::PH_IDLE;
    fr_accum     = '0;
    fr_len_left  = '0;
    fr_body_left = '0;
    fr_partial   = 1'b0;
    fr_count     = '0;
  endtask

  task automatic body_start(input logic [31:0] len, input logic partial, output logic ends);
    fr_partial   = partial;
    fr_body_left = len;
    fr_accum     = '0;
    fr_len_left  = '0;
    ends         = 1'b0;
    if (len == 32'd0) begin
      if (partial) fr_phase = opf_pkg::PH_NEWLEN;
      else ends = 1'b1;
    end else begin
      fr_phase = opf_pkg::PH_BODY;
    end
  endtask

  task automatic frame_step(input logic k, input logic [7:0] b, output opf_pkg::result_t r);
    logic done;
    r    = R_CLEAN;
    done = 1'b0;
    if (k != opf_pkg::KIND_BYTE) begin
      if (fr_phase != opf_pkg::PH_IDLE) r.status = opf_pkg::ST_TRUNC;
      frame_clear();
    end else begin
      case (fr_phase)
        opf_pkg::PH_IDLE: begin
          if (!b[7]) begin
            r.status = opf_pkg::ST_NOTAG;
            frame_clear();
          end else if (b[6]) begin
            r.byte_valid = 1'b1;
            r.out_byte   = b;
            fr_count     = 32'd1;
            fr_phase     = opf_pkg::PH_NEWLEN;
          end else if (b[1:0] == opf_pkg::OLD_LEN_INDET) begin
            r.status = opf_pkg::ST_INDET;
            frame_clear();
          end else begin
            r.byte_valid = 1'b1;
            r.out_byte   = {opf_pkg::OLD_TAG_HIGH, b[5:2]};
            fr_count     = 32'd1;
            fr_accum     = '0;
            fr_len_left  = (b[1:0] == opf_pkg::OLD_LEN_ONE) ? 3'd1 :
                           (b[1:0] == opf_pkg::OLD_LEN_TWO) ? 3'd2 : 3'd4;
            fr_phase     = opf_pkg::PH_MULTI;
          end
        end
        opf_pkg::PH_NEWLEN: begin
          if (b < opf_pkg::LEN_TWO_MIN) begin
            body_start({24'd0, b}, 1'b0, done);
          end else if (b <= opf_pkg::LEN_TWO_MAX) begin
            fr_accum = {16'd0, b - opf_pkg::LEN_TWO_MIN, 8'd0};
            fr_phase = opf_pkg::PH_TWO;
          end else if (b < opf_pkg::LEN_FIVE) begin
            body_start(32'd1 << b[4:0], 1'b1, done);
          end else begin
            fr_accum    = '0;
            fr_len_left = 3'd4;
            fr_phase    = opf_pkg::PH_MULTI;
          end
        end
        opf_pkg::PH_TWO: body_start(fr_accum + {24'd0, b} + 32'd192, 1'b0, done);
        opf_pkg::PH_MULTI: begin
          fr_accum = {fr_accum[23:0], b};
          if (fr_len_left != 3'd0) fr_len_left = fr_len_left - 3'd1;
          if (fr_len_left == 3'd0) body_start(fr_accum, 1'b0, done);
        end
        default: begin
          r.byte_valid = 1'b1;
          r.out_byte   = b;
          if (fr_count != 32'hFFFF_FFFF) fr_count = fr_count + 32'd1;
          if (fr_body_left != 32'd0) fr_body_left = fr_body_left - 32'd1;
          if (fr_body_left == 32'd0) begin
            if (fr_partial) begin
              fr_partial = 1'b0;
              fr_phase   = opf_pkg::PH_NEWLEN;
            end else begin
              done = 1'b1;
            end
          end
        end
      endcase
      if (done) begin
        r.packet_done  = 1'b1;
        r.packet_bytes = fr_count;
        frame_clear();
      end
    end
  endtask

  task automatic send_item(input logic k, input logic [7:0] b, input logic typed,
                           input opf_pkg::result_t want);
    opf_pkg::result_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    data_byte  <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    frame_step(k, b, pred);
    frame_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(opf_pkg::KIND_BYTE, b, 1'b0, R_CLEAN);
  endtask

  task automatic send_end();
    send_item(KIND_END, 8'($urandom_range(0, 255)), 1'b0, R_CLEAN);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk);
  endtask

  // one packet, a broken one, or noise
  task automatic random_packet();
    logic [7:0] pkt_q [$];
    int sel, len, cut, e, v, t, nparts;
    logic end_mark;
    end_mark = 1'b0;
    if (fr_phase != opf_pkg::PH_IDLE) send_end();
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      pkt_q.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 10) begin
      end_mark = 1'b1;
    end else if (sel < 15) begin
      if ($urandom_range(0, 1)) pkt_q.push_back({1'b0, 7'($urandom_range(0, 127))});
      else pkt_q.push_back({2'b10, 4'($urandom_range(0, 15)), opf_pkg::OLD_LEN_INDET});
    end else if (sel < 25) begin
      // long and partial length headers, then end of stream, which usually cuts them short
      case ($urandom_range(0, 4))
        0: begin
          pkt_q.push_back({2'b11, 6'($urandom_range(0, 63))});
          pkt_q.push_back(8'($urandom_range(192, 223)));
          pkt_q.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          pkt_q.push_back({2'b11, 6'($urandom_range(0, 63))});
          pkt_q.push_back(8'($urandom_range(224, 254)));
        end
        2: begin
          pkt_q.push_back({2'b11, 6'($urandom_range(0, 63))});
          pkt_q.push_back(opf_pkg::LEN_FIVE);
          if ($urandom_range(0, 3) == 0) repeat (4) pkt_q.push_back(8'hFF);
          else repeat (4) pkt_q.push_back(8'($urandom_range(0, 255)));
        end
        3: begin
          pkt_q.push_back({2'b10, 4'($urandom_range(0, 15)), opf_pkg::OLD_LEN_TWO});
          repeat (2) pkt_q.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          pkt_q.push_back({2'b10, 4'($urandom_range(0, 15)), 2'd2});
          repeat (4) pkt_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      repeat ($urandom_range(0, 3)) pkt_q.push_back(8'($urandom_range(0, 255)));
      end_mark = 1'b1;
    end else begin
      if ($urandom_range(0, 1)) begin
        pkt_q.push_back({2'b11, 6'($urandom_range(0, 63))});
        nparts = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (nparts) begin
          e = $urandom_range(0, 3);
          pkt_q.push_back(8'(224 + e));
          repeat (1 << e) pkt_q.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 2))
          0: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 191) :
                                                 $urandom_range(0, 12);
            pkt_q.push_back(8'(len));
          end
          1: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(192, 260) :
                                                 $urandom_range(192, 200);
            v = len - 192;
            pkt_q.push_back(8'(192 + (v >> 8)));
            pkt_q.push_back(8'(v));
          end
          default: begin
            len = $urandom_range(0, 12);
            pkt_q.push_back(opf_pkg::LEN_FIVE);
            pkt_q.push_back(8'(len >> 24));
            pkt_q.push_back(8'(len >> 16));
            pkt_q.push_back(8'(len >> 8));
            pkt_q.push_back(8'(len));
          end
        endcase
      end else begin
        t = $urandom_range(0, 2);
        pkt_q.push_back({2'b10, 4'($urandom_range(0, 15)), 2'(t)});
        len = (t == 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                                                      $urandom_range(0, 12);
        if (t == 2) begin
          pkt_q.push_back(8'(len >> 24));
          pkt_q.push_back(8'(len >> 16));
        end
        if (t != 0) pkt_q.push_back(8'(len >> 8));
        pkt_q.push_back(8'(len));
      end
      repeat (len) pkt_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 15 && pkt_q.size() > 1) begin
        cut = $urandom_range(1, pkt_q.size() - 1);
        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
        end_mark = 1'b1;
      end
    end
    foreach (pkt_q[i]) send_byte(pkt_q[i]);
    if (end_mark) send_end();
  endtask

  task automatic check_result();
    opf_pkg::result_t got, want;
    got = '{byte_valid, out_byte, packet_done, opf_pkg::status_t'(status), packet_bytes};
    if (frame_q.size() == 0) begin
      if (bad_count < 10)
        $display("unexpected result: valid=%0d byte=%h done=%0d status=%0d bytes=%0d",
                 got.byte_valid, got.out_byte, got.packet_done, got.status,
                 got.packet_bytes);
      bad_count++;
    end else begin
      want = frame_q.pop_front();
      if (got !== want) begin
        if (bad_count < 10)
          $display({"mismatch: expected valid=%0d byte=%h done=%0d status=%0d bytes=%0d,",
                    " got valid=%0d byte=%h done=%0d status=%0d bytes=%0d"},
                   want.byte_valid, want.out_byte, want.packet_done, want.status,
                   want.packet_bytes, got.byte_valid, got.out_byte, got.packet_done,
                   got.status, got.packet_bytes);
        bad_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result();
  end

  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("openpgp_packet_framer verification failed");
      $finish;
    end
  end

  initial begin
    int base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].k, DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS / 3) random_packet();
    // hold the stream until every pending result is out
    wait_drained();
    send_gap_pct   = 85;
    recv_stall_pct = 17;
    while (items_sent - base < 2 * RANDOM_ITEMS / 3) random_packet();
    wait_drained();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    while (items_sent - base < RANDOM_ITEMS) random_packet();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0 && frame_q.size() == 0) begin
      $display("openpgp_packet_framer verification clean");
    end else begin
      $display("openpgp_packet_framer verification failed");
    end
    $finish;
  end

endmodule
